// ----- sv/fbp_pkg.sv -----
package fbp_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int FILES_PER_RANK = 8;
	localparam int SPACES_WANTED = 5;
	localparam int SPACES_MAX = 6;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_DIGIT_LO = 8'd48;
	localparam logic [7:0] CH_DIGIT_HI = 8'd57;
	localparam logic [7:0] CH_UPPER_LO = 8'd65;
	localparam logic [7:0] CH_UPPER_HI = 8'd90;

	localparam logic [4:0] COLOUR_WHITE = 5'd8;
	localparam logic [4:0] COLOUR_BLACK = 5'd16;

	localparam logic RK_SQUARE = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	typedef enum logic [2:0] {
		OP_END   = 3'd0,
		OP_SPACE = 3'd1,
		OP_SLASH = 3'd2,
		OP_DIGIT = 3'd3,
		OP_PIECE = 3'd4,
		OP_OTHER = 3'd5
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [3:0] digit;
		logic [4:0] piece;
	} op_t;

	function automatic logic [2:0] piece_class(input logic [7:0] c);
		logic [2:0] t;
		begin
			case (c)
				8'd107, 8'd75: t = 3'd1;
				8'd112, 8'd80: t = 3'd2;
				8'd110, 8'd78: t = 3'd3;
				8'd98, 8'd66:  t = 3'd4;
				8'd114, 8'd82: t = 3'd5;
				8'd113, 8'd81: t = 3'd6;
				default:       t = 3'd0;
			endcase
			return t;
		end
	endfunction

endpackage

// ----- sv/fbp_front.sv -----
module fbp_front import fbp_pkg::*; (
	input  logic [7:0] char_code,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	logic [4:0] colour;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		colour = (char_code inside {[CH_UPPER_LO:CH_UPPER_HI]}) ? COLOUR_WHITE : COLOUR_BLACK;
		q_op.digit = char_code[3:0];
		q_op.piece = {2'b00, piece_class(char_code)} | colour;
		if (char_code == CH_NUL)
			q_op.kind = OP_END;
		else if (char_code == CH_SPACE)
			q_op.kind = OP_SPACE;
		else if (char_code == CH_SLASH)
			q_op.kind = OP_SLASH;
		else if (char_code inside {[CH_DIGIT_LO:CH_DIGIT_HI]})
			q_op.kind = OP_DIGIT;
		else
			q_op.kind = OP_PIECE;
	end

endmodule

// ----- sv/fbp_queue.sv -----
module fbp_queue import fbp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output op_t  q_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_op = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count past depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !q_valid)) else $error("pop from empty queue");

endmodule

// ----- sv/fbp_back.sv -----
module fbp_back import fbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       pop,
	output logic       result_kind,
	output logic [5:0] square_index,
	output logic [4:0] piece_id,
	output logic       failed,
	output logic       out_valid,
	input  logic       out_stall
);

	logic       in_placement_q;
	logic [3:0] file_q;
	logic [2:0] rank_q;
	logic [2:0] spaces_q;
	logic       ovf_q;
	logic       out_valid_q;
	logic       kind_q;
	logic [5:0] sq_q;
	logic [4:0] pc_q;
	logic       fail_q;
	logic [4:0] nf;
	logic       res_now;

	assign pop = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign square_index = sq_q;
	assign piece_id = pc_q;
	assign failed = fail_q;
	assign nf = {1'b0, file_q} + {1'b0, q_op.digit};
	// a beat leaves on every end byte and on each in-bounds piece
	assign res_now = pop && ((q_op.kind == OP_END) ||
		((q_op.kind == OP_PIECE || q_op.kind == OP_OTHER) && in_placement_q && !ovf_q
		&& file_q < 4'(FILES_PER_RANK)));

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_op.kind == OP_END) begin
				kind_q <= RK_STATUS;
				sq_q <= '0;
				pc_q <= '0;
				fail_q <= in_placement_q || ovf_q || (spaces_q != 3'(SPACES_WANTED));
			end else begin
				kind_q <= RK_SQUARE;
				sq_q <= {rank_q, file_q[2:0]};
				pc_q <= q_op.piece;
				fail_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_placement_q <= 1'b1;
			file_q <= '0;
			rank_q <= 3'd7;
			spaces_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_now || (out_valid_q && out_stall);
			if (pop) begin
				case (q_op.kind)
					OP_END: begin
						in_placement_q <= 1'b1;
						file_q <= '0;
						rank_q <= 3'd7;
						spaces_q <= '0;
						ovf_q <= 1'b0;
					end
					OP_SPACE: begin
						in_placement_q <= 1'b0;
						if (spaces_q < 3'(SPACES_MAX))
							spaces_q <= spaces_q + 1'b1;
					end
					OP_SLASH: begin
						if (in_placement_q) begin
							file_q <= '0;
							if (rank_q == '0)
								ovf_q <= 1'b1;
							else
								rank_q <= rank_q - 1'b1;
						end
					end
					OP_DIGIT: begin
						if (in_placement_q) begin
							if (nf > 5'(FILES_PER_RANK)) begin
								ovf_q <= 1'b1;
								file_q <= 4'(FILES_PER_RANK);
							end else begin
								file_q <= nf[3:0];
							end
						end
					end
					OP_PIECE, OP_OTHER: begin
						if (in_placement_q) begin
							if (ovf_q || file_q >= 4'(FILES_PER_RANK)) begin
								ovf_q <= 1'b1;
							end else begin
								file_q <= file_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	a_file_bound: assert property (@(posedge clk) disable iff (!arst_n)
		file_q <= 4'(FILES_PER_RANK)) else $error("file past board edge");
	a_space_sat: assert property (@(posedge clk) disable iff (!arst_n)
		spaces_q <= 3'(SPACES_MAX)) else $error("space count past saturation");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_op.kind == OP_END |=> in_placement_q && !ovf_q && spaces_q == '0
		&& out_valid_q && kind_q == RK_STATUS) else $error("end of string left state");

endmodule

// ----- sv/fen_board_parser.sv -----
// An accepted byte waits in the op queue; the back end pops it, updates the
// board state and registers its result beat, one byte per cycle while the
// queue has room; by default it holds two ops, filling while results stall.
// Reset (arst_n low, async): queue empty, no result, placement field, rank 7,
// file 0, no spaces, no overflow.
module fen_board_parser import fbp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       result_kind,
	output logic [5:0] square_index,
	output logic [4:0] piece_id,
	output logic       failed,
	output logic       out_valid,
	input  logic       out_stall
);

	logic q_full;
	logic q_push;
	op_t  push_op;
	logic q_pop;
	logic q_valid;
	op_t  q_op;

	fbp_front u_front (
		.char_code (char_code),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	fbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.q_valid (q_valid),
		.q_op    (q_op)
	);

	fbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.pop          (q_pop),
		.result_kind  (result_kind),
		.square_index (square_index),
		.piece_id     (piece_id),
		.failed       (failed),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import fbp_pkg::*;

	localparam logic [4:0] PT_NONE   = 5'd0;
	localparam logic [4:0] PT_KING   = 5'd1;
	localparam logic [4:0] PT_PAWN   = 5'd2;
	localparam logic [4:0] PT_KNIGHT = 5'd3;
	localparam logic [4:0] PT_BISHOP = 5'd4;
	localparam logic [4:0] PT_ROOK   = 5'd5;
	localparam logic [4:0] PT_QUEEN  = 5'd6;

	localparam int RANDOM_BYTES = 750;

	typedef struct packed {
		logic       kind;
		logic [5:0] sq;
		logic [4:0] pc;
		logic       fail;
	} parse_beat_t;

	typedef struct {
		bit         drain;
		logic [7:0] ch;
	} fen_feed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] char_code = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       result_kind;
	logic [5:0] square_index;
	logic [4:0] piece_id;
	logic       failed;
	logic       out_valid;
	logic       out_stall = 1'b0;

	fen_board_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.result_kind  (result_kind),
		.square_index (square_index),
		.piece_id     (piece_id),
		.failed       (failed),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	fen_feed_t   fen_bytes_q[$];
	logic [7:0]  fen_text[$];
	parse_beat_t parse_out_q[$];

	// board tracking state
	logic       pl_in_field;
	logic [4:0] pl_file;
	logic [2:0] pl_rank;
	logic [2:0] pl_spaces;
	logic       pl_overflow;

	int  mismatches = 0;
	int  bytes_total = 0;
	int  bytes_seen = 0;
	int  square_count = 0;
	int  status_count = 0;
	int  clean_count = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5ms;
		$display("timeout: %0d of %0d bytes taken, %0d beats outstanding",
			bytes_seen, bytes_total, parse_out_q.size());
		$display("FAIL fen_board_parser");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [4:0] piece_kind(input logic [7:0] c);
		case (c)
			"k", "K": return PT_KING;
			"p", "P": return PT_PAWN;
			"n", "N": return PT_KNIGHT;
			"b", "B": return PT_BISHOP;
			"r", "R": return PT_ROOK;
			"q", "Q": return PT_QUEEN;
			default:  return PT_NONE;
		endcase
	endfunction

	task automatic clear_parse_state();
		pl_in_field = 1'b1;
		pl_file     = 5'd0;
		pl_rank     = 3'd7;
		pl_spaces   = 3'd0;
		pl_overflow = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] c);
		parse_beat_t b;
		int nf;
		b = '0;
		bytes_seen++;
		if (c == CH_NUL) begin
			b.kind = RK_STATUS;
			b.fail = pl_in_field || pl_overflow || (pl_spaces != SPACES_WANTED);
			parse_out_q.push_back(b);
			status_count++;
			if (!b.fail)
				clean_count++;
			clear_parse_state();
		end else if (c == CH_SPACE) begin
			pl_in_field = 1'b0;
			if (pl_spaces < SPACES_MAX)
				pl_spaces++;
		end else if (pl_in_field) begin
			if (c == CH_SLASH) begin
				pl_file = 5'd0;
				if (pl_rank == 3'd0)
					pl_overflow = 1'b1;
				else
					pl_rank--;
			end else if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
				nf = pl_file + (c - CH_DIGIT_LO);
				if (nf > FILES_PER_RANK) begin
					pl_overflow = 1'b1;
					nf = FILES_PER_RANK;
				end
				pl_file = 5'(nf);
			end else if (pl_overflow || pl_file >= FILES_PER_RANK) begin
				pl_overflow = 1'b1;
			end else begin
				b.kind = RK_SQUARE;
				b.sq   = {pl_rank, pl_file[2:0]};
				b.pc   = piece_kind(c) |
					((c >= CH_UPPER_LO && c <= CH_UPPER_HI) ? COLOUR_WHITE : COLOUR_BLACK);
				parse_out_q.push_back(b);
				square_count++;
				pl_file++;
			end
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : feed_proc
		bit         go;
		logic [7:0] nxt;
		fen_feed_t  head;
		go = 1'b0;
		nxt = char_code;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= CH_NUL;
			send_gap = 0;
			clear_parse_state();
		end else begin
			if ($urandom_range(0, 79) == 0)
				send_quiet = !send_quiet;
			if (in_valid && !in_stall) begin
				parse_byte(char_code);
				send_gap = pick_gap(send_quiet);
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (fen_bytes_q.size() > 0) begin
					if (fen_bytes_q[0].drain) begin
						if (parse_out_q.size() == 0)
							void'(fen_bytes_q.pop_front());
					end else begin
						head = fen_bytes_q.pop_front();
						go = 1'b1;
						nxt = head.ch;
					end
				end
				in_valid <= go;
				char_code <= nxt;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin : check_proc
		parse_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if ($urandom_range(0, 79) == 0)
				recv_quiet = !recv_quiet;
			if (out_valid && !out_stall) begin
				if (parse_out_q.size() == 0) begin
					report_mismatch("beat with nothing pending", result_kind, 0);
				end else begin
					want = parse_out_q.pop_front();
					if (result_kind !== want.kind)
						report_mismatch("result_kind", result_kind, want.kind);
					if (square_index !== want.sq)
						report_mismatch("square_index", square_index, want.sq);
					if (piece_id !== want.pc)
						report_mismatch("piece_id", piece_id, want.pc);
					if (failed !== want.fail)
						report_mismatch("failed", failed, want.fail);
				end
			end
			if (stall_left == 0)
				stall_left = pick_gap(recv_quiet);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task automatic text_append(input string s);
		for (int i = 0; i < s.len(); i++)
			fen_text.push_back(s[i]);
	endtask

	function automatic logic [7:0] odd_byte();
		case ($urandom_range(0, 5))
			0:       return CH_SPACE;
			1:       return CH_SLASH;
			2:       return "9";
			3:       return "0";
			4:       return CH_NUL;
			default: return "k";
		endcase
	endfunction

	task automatic add_placement();
		string pcs;
		int f;
		int d;
		pcs = "KQRBNPkqrbnp";
		for (int rk = 0; rk < 8; rk++) begin
			if (rk != 0)
				fen_text.push_back(CH_SLASH);
			f = 0;
			while (f < FILES_PER_RANK) begin
				if ($urandom_range(0, 2) == 0) begin
					d = $urandom_range(1, FILES_PER_RANK - f);
					fen_text.push_back(8'(CH_DIGIT_LO + d));
					f += d;
				end else begin
					fen_text.push_back(pcs[$urandom_range(0, 11)]);
					f++;
				end
			end
		end
	endtask

	task automatic add_fields();
		string rights;
		bit any;
		rights = "KQkq";
		any = 1'b0;
		text_append($urandom_range(0, 1) ? " w " : " b ");
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 1)) begin
				fen_text.push_back(rights[i]);
				any = 1'b1;
			end
		end
		if (!any)
			text_append("-");
		text_append(" ");
		if ($urandom_range(0, 2) == 0) begin
			fen_text.push_back(8'("a" + $urandom_range(0, 7)));
			text_append($urandom_range(0, 1) ? "3" : "6");
		end else begin
			text_append("-");
		end
		text_append($sformatf(" %0d %0d", $urandom_range(0, 99), $urandom_range(1, 199)));
	endtask

	task automatic commit_string(input bit mangle);
		int pos;
		if (mangle) begin
			repeat ($urandom_range(1, 3)) begin
				pos = $urandom_range(0, fen_text.size() - 1);
				case ($urandom_range(0, 4))
					0: fen_text[pos] = 8'($urandom_range(0, 255));
					1: fen_text[pos] = odd_byte();
					2: if (fen_text.size() > 1) fen_text.delete(pos);
					3: fen_text.insert(pos, odd_byte());
					default: text_append(" -");
				endcase
			end
		end
		foreach (fen_text[i])
			fen_bytes_q.push_back('{drain: 1'b0, ch: fen_text[i]});
		fen_bytes_q.push_back('{drain: 1'b0, ch: CH_NUL});
		bytes_total += fen_text.size() + 1;
		fen_text.delete();
	endtask

	initial begin : stimulus
		int kind;
		// king, unknown lowercase, top byte, unknown uppercase, digit past the
		// edge, then a terminator still inside the placement field
		text_append("Kx");
		fen_text.push_back(8'hFF);
		text_append("Z9");
		commit_string(1'b0);
		// rank underflow, then a piece that must stay silent
		text_append("////////p");
		commit_string(1'b0);
		// piece off the end of a rank, a byte after placement, five spaces
		text_append("8n  q   ");
		commit_string(1'b0);
		fen_bytes_q.push_back('{drain: 1'b1, ch: CH_NUL});

		while (bytes_total < RANDOM_BYTES + 25) begin
			kind = $urandom_range(0, 9);
			if (kind < 9) begin
				add_placement();
				add_fields();
				commit_string(kind >= 6);
			end else begin
				repeat ($urandom_range(1, 24))
					fen_text.push_back(($urandom_range(0, 3) == 0) ? odd_byte() :
						8'($urandom_range(1, 255)));
				commit_string(1'b0);
			end
			if ($urandom_range(0, 7) == 0)
				fen_bytes_q.push_back('{drain: 1'b1, ch: CH_NUL});
		end

		wait (arst_n === 1'b1);
		while (bytes_seen != bytes_total || parse_out_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (parse_out_q.size() != 0)
			report_mismatch("beats never delivered", 0, parse_out_q.size());

		$display("run covered %0d bytes: %0d square writes, %0d end-of-string results",
			bytes_seen, square_count, status_count);
		$display("%0d strings parsed cleanly, %0d rejected, %0d mismatches",
			clean_count, status_count - clean_count, mismatches);
		if (mismatches == 0)
			$display("PASS fen_board_parser");
		else
			$display("FAIL fen_board_parser");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/fbp_pkg.sv
sv/fbp_front.sv
sv/fbp_queue.sv
sv/fbp_back.sv
sv/fen_board_parser.sv
bench/tb.sv
